@@ sv/mchb_pkg.sv @@
// Shared types and constants for the multi-channel heartbeat timeout block.
package mchb_pkg;

    localparam int IN_TIME_W = 32;
    localparam int SLOT_W    = 4;
    localparam int MAX_SLOTS = 16;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_DELETE   = 2'd1,
        OP_KICK     = 2'd2,
        OP_SCAN     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN
    } t_state;

    localparam logic KIND_REG  = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef struct packed {
        t_op                  op;
        logic [SLOT_W-1:0]    slot;
        logic                 in_range;
        logic [IN_TIME_W-1:0] timeout;
        logic [IN_TIME_W-1:0] now;
    } t_cmd;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot_out;
        logic              ok;
        logic              offline;
        logic              last;
    } t_result;

endpackage

@@ sv/multi_channel_heartbeat_timeout.sv @@
// Top level of the multi-channel heartbeat timeout watchdog.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  command | in        | push / full (queue-in)  | i_func i_slot i_timeout_ms i_now_ms
//  result  | out       | empty / pop (queue-out) | o_kind o_slot_out o_ok o_offline o_last
//
// Sequence: delete and kick are handled in the idle state; register is dispatched, then
//   walks the table one slot per cycle to the first free slot, waiting there while the
//   result queue is full; scan walks every slot, holding at enabled ones while it is full;
//   the first scan and a register before it are handled in idle. Commands queue first.
// Reset: synchronous, active low; clears the armed flag, all enable bits and both
//   queues at once. No clearing pass; the block is ready the cycle after reset.
// Stalls: a result waits in the engine while the two-entry result queue is full;
//   full rises once two commands wait in the command queue.
module multi_channel_heartbeat_timeout #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command transfer
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     i_func,
    input  logic [mchb_pkg::SLOT_W-1:0]    i_slot,
    input  logic [mchb_pkg::IN_TIME_W-1:0] i_timeout_ms,
    input  logic [mchb_pkg::IN_TIME_W-1:0] i_now_ms,
    // result transfer
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_kind,
    output logic [mchb_pkg::SLOT_W-1:0]    o_slot_out,
    output logic                           o_ok,
    output logic                           o_offline,
    output logic                           o_last
);

    // slot fields are 4 bits wide, so at most 16 slots are reachable
    localparam int NSLOT = (SLOTS < mchb_pkg::MAX_SLOTS) ? SLOTS : mchb_pkg::MAX_SLOTS;

    logic              cmd_valid;
    logic              cmd_take;
    mchb_pkg::t_cmd    cmd;
    logic              res_push;
    logic              res_full;
    mchb_pkg::t_result res_in;
    mchb_pkg::t_result res_out;

    // front end: decode and queue commands
    mchb_front #(
        .N_SLOT(NSLOT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_func       (i_func),
        .i_slot       (i_slot),
        .i_timeout_ms (i_timeout_ms),
        .i_now_ms     (i_now_ms),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_take   (cmd_take)
    );

    // back end: slot table and sequencer
    mchb_engine #(
        .N_SLOT    (NSLOT),
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // results wait here until popped; the engine keeps working while there is room
    mchb_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res_out)
    );

    assign o_kind     = res_out.kind;
    assign o_slot_out = res_out.slot_out;
    assign o_ok       = res_out.ok;
    assign o_offline  = res_out.offline;
    assign o_last     = res_out.last;

endmodule

@@ sv/mchb_front.sv @@
// Front end: accepts input items, decodes them and queues commands for the engine.
module mchb_front #(
    parameter int N_SLOT = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [1:0]                        i_func,
    input  logic [mchb_pkg::SLOT_W-1:0]       i_slot,
    input  logic [mchb_pkg::IN_TIME_W-1:0]    i_timeout_ms,
    input  logic [mchb_pkg::IN_TIME_W-1:0]    i_now_ms,
    output logic                              o_cmd_valid,
    output mchb_pkg::t_cmd                    o_cmd,
    input  logic                              i_cmd_take
);

    mchb_pkg::t_cmd r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    mchb_pkg::t_cmd dec;
    logic           wr_en;
    logic           rd_en;

    // decode: operation code and slot range check
    always_comb begin
        dec.op       = mchb_pkg::t_op'(i_func);
        dec.slot     = i_slot;
        dec.in_range = ({1'b0, i_slot} < 5'(N_SLOT));
        dec.timeout  = i_timeout_ms;
        dec.now      = i_now_ms;
    end

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) r_wr_ptr <= ~r_wr_ptr;
            if (rd_en) r_rd_ptr <= ~r_rd_ptr;
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_q[r_wr_ptr] <= dec;
    end

endmodule

@@ sv/mchb_engine.sv @@
// Back end: slot table, free-slot search and scan sequencer.
module mchb_engine #(
    parameter int N_SLOT    = 16,
    parameter int TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  mchb_pkg::t_cmd    i_cmd,
    output logic              o_cmd_take,
    input  logic              i_res_full,
    output logic              o_res_push,
    output mchb_pkg::t_result o_res
);

    localparam int IDX_W = (N_SLOT > 1) ? $clog2(N_SLOT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(N_SLOT - 1);

    mchb_pkg::t_state     r_state, n_state;
    logic                 r_ready;
    logic [N_SLOT-1:0]    r_en;
    logic [IDX_W-1:0]     r_idx;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_tmo;
    logic [TIME_BITS-1:0] r_heard [N_SLOT];
    logic [TIME_BITS-1:0] r_limit [N_SLOT];

    logic [63:0]          cmd_now64, cmd_tmo64;
    logic [TIME_BITS-1:0] cmd_now, cmd_tmo;
    logic [IDX_W-1:0]     cmd_idx;
    logic                 cur_en;
    logic [TIME_BITS-1:0] age;
    logic                 offline;
    logic [N_SLOT-1:0]    above;
    logic                 last_hit;

    // control from the output block
    logic                 latch, step, ready_set, en_clr, en_wr, en_val;
    logic                 heard_wr, lim_wr;
    logic [IDX_W-1:0]     wr_idx;
    logic [TIME_BITS-1:0] heard_val, lim_val;

    assign cmd_now64 = {32'b0, i_cmd.now};
    assign cmd_tmo64 = {32'b0, i_cmd.timeout};
    assign cmd_now   = cmd_now64[TIME_BITS-1:0];
    assign cmd_tmo   = cmd_tmo64[TIME_BITS-1:0];
    assign cmd_idx   = i_cmd.slot[IDX_W-1:0];

    assign cur_en  = r_en[r_idx];
    assign age     = r_now - r_heard[r_idx];
    assign offline = (age > r_limit[r_idx]);

    always_comb begin
        for (int j = 0; j < N_SLOT; j++) begin
            above[j] = ((IDX_W+1)'(j) > {1'b0, r_idx});
        end
    end
    assign last_hit = ~|(r_en & above);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mchb_pkg::ST_IDLE: begin
                if (i_cmd_valid && r_ready) begin
                    if (i_cmd.op == mchb_pkg::OP_REGISTER) n_state = mchb_pkg::ST_SEARCH;
                    else if (i_cmd.op == mchb_pkg::OP_SCAN) n_state = mchb_pkg::ST_SCAN;
                end
            end
            mchb_pkg::ST_SEARCH: begin
                if ((!cur_en || r_idx == IDX_LAST) && !i_res_full) n_state = mchb_pkg::ST_IDLE;
            end
            mchb_pkg::ST_SCAN: begin
                if (r_idx == IDX_LAST && (!cur_en || !i_res_full)) n_state = mchb_pkg::ST_IDLE;
            end
            default: n_state = mchb_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_take = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        latch      = 1'b0;
        step       = 1'b0;
        ready_set  = 1'b0;
        en_clr     = 1'b0;
        en_wr      = 1'b0;
        en_val     = 1'b0;
        heard_wr   = 1'b0;
        lim_wr     = 1'b0;
        wr_idx     = r_idx;
        heard_val  = r_now;
        lim_val    = r_tmo;
        unique case (r_state)
            mchb_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        mchb_pkg::OP_REGISTER: begin
                            if (r_ready) begin
                                o_cmd_take = 1'b1;
                                latch      = 1'b1;
                            end else if (!i_res_full) begin
                                // not armed yet: refuse at once
                                o_cmd_take   = 1'b1;
                                o_res_push   = 1'b1;
                                o_res.kind   = mchb_pkg::KIND_REG;
                                o_res.last   = 1'b1;
                            end
                        end
                        mchb_pkg::OP_DELETE: begin
                            o_cmd_take = 1'b1;
                            if (r_ready && i_cmd.in_range) begin
                                en_wr     = 1'b1;
                                wr_idx    = cmd_idx;
                                heard_wr  = 1'b1;
                                heard_val = cmd_now;
                                lim_wr    = 1'b1;
                                lim_val   = '0;
                            end
                        end
                        mchb_pkg::OP_KICK: begin
                            o_cmd_take = 1'b1;
                            if (r_ready && i_cmd.in_range && r_en[cmd_idx]) begin
                                wr_idx    = cmd_idx;
                                heard_wr  = 1'b1;
                                heard_val = cmd_now;
                            end
                        end
                        mchb_pkg::OP_SCAN: begin
                            o_cmd_take = 1'b1;
                            if (!r_ready) begin
                                // first scan arms the block; table starts empty
                                ready_set = 1'b1;
                                en_clr    = 1'b1;
                            end else begin
                                latch = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mchb_pkg::ST_SEARCH: begin
                if (!cur_en || r_idx == IDX_LAST) begin
                    if (!i_res_full) begin
                        o_res_push     = 1'b1;
                        o_res.kind     = mchb_pkg::KIND_REG;
                        o_res.ok       = !cur_en;
                        o_res.slot_out = cur_en ? '0 : mchb_pkg::SLOT_W'(r_idx);
                        o_res.last     = 1'b1;
                        if (!cur_en) begin
                            en_wr    = 1'b1;
                            en_val   = 1'b1;
                            heard_wr = 1'b1;
                            lim_wr   = 1'b1;
                        end
                    end
                end else begin
                    step = 1'b1;
                end
            end
            mchb_pkg::ST_SCAN: begin
                if (cur_en && !i_res_full) begin
                    o_res_push     = 1'b1;
                    o_res.kind     = mchb_pkg::KIND_SCAN;
                    o_res.slot_out = mchb_pkg::SLOT_W'(r_idx);
                    o_res.ok       = 1'b1;
                    o_res.offline  = offline;
                    o_res.last     = last_hit;
                end
                step = (r_idx != IDX_LAST) && (!cur_en || !i_res_full);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mchb_pkg::ST_IDLE;
            r_ready <= 1'b0;
            r_en    <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (ready_set) r_ready <= 1'b1;
            if (en_clr) r_en <= '0;
            else if (en_wr) r_en[wr_idx] <= en_val;
            if (latch) r_idx <= '0;
            else if (step) r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (latch) begin
            r_now <= cmd_now;
            r_tmo <= cmd_tmo;
        end
        if (heard_wr) r_heard[wr_idx] <= heard_val;
        if (lim_wr) r_limit[wr_idx] <= lim_val;
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");

    a_busy_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mchb_pkg::ST_IDLE) |-> r_ready)
        else $error("sequencer busy before first scan");

    a_reg_claims_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && r_state == mchb_pkg::ST_SEARCH && o_res.ok) |=> r_en[$past(r_idx)])
        else $error("granted slot not enabled");

    a_scan_only_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.kind == mchb_pkg::KIND_SCAN) |-> r_en[r_idx])
        else $error("scan status for disabled slot");

endmodule

@@ sv/mchb_result_q.sv @@
// Two-entry result queue between the engine and the output ports.
module mchb_result_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mchb_pkg::t_result i_res,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output mchb_pkg::t_result o_res
);

    mchb_pkg::t_result r_q [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_res   = r_q[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) r_wr_ptr <= ~r_wr_ptr;
            if (rd_en) r_rd_ptr <= ~r_rd_ptr;
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_q[r_wr_ptr] <= i_res;
    end

endmodule
